// ===== rtl/core/cpu8_alu_with_bcd_assert.svh =====
// Assertion macros for the 8-bit ALU core.
// No dependencies; included by the top level only.
`ifndef CPU8_ALU_WITH_BCD_ASSERT_SVH
`define CPU8_ALU_WITH_BCD_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPU8ALU_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPU8ALU_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/cpu8alu_pkg.sv =====
// Package for the 8-bit ALU core: word types, op and destination codes,
// flag positions and decimal-adjust constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpu8alu_pkg;

	// operation codes
	localparam logic [3:0] OP_ADC = 4'd0;
	localparam logic [3:0] OP_SBC = 4'd1;
	localparam logic [3:0] OP_AND = 4'd2;
	localparam logic [3:0] OP_ORA = 4'd3;
	localparam logic [3:0] OP_EOR = 4'd4;
	localparam logic [3:0] OP_BIT = 4'd5;
	localparam logic [3:0] OP_INC = 4'd6;
	localparam logic [3:0] OP_DEC = 4'd7;
	localparam logic [3:0] OP_INX = 4'd8;
	localparam logic [3:0] OP_INY = 4'd9;
	localparam logic [3:0] OP_DEX = 4'd10;
	localparam logic [3:0] OP_DEY = 4'd11;

	// destination codes
	localparam logic [2:0] DEST_ACC  = 3'd0;
	localparam logic [2:0] DEST_X    = 3'd1;
	localparam logic [2:0] DEST_Y    = 3'd2;
	localparam logic [2:0] DEST_MEM  = 3'd3;
	localparam logic [2:0] DEST_NONE = 3'd4;

	// status bit positions
	localparam int FLAG_N = 7;
	localparam int FLAG_V = 6;
	localparam int FLAG_D = 3;
	localparam int FLAG_Z = 1;
	localparam int FLAG_C = 0;

	// decimal adjust
	localparam logic [4:0] BCD_DIGIT_MAX = 5'd9;
	localparam logic [3:0] BCD_ADJ_LO    = 4'd6;
	localparam logic [3:0] BCD_LO_WRAP   = 4'd10;
	localparam logic [8:0] BCD_HI_LIMIT  = 9'h0A0;
	localparam logic [9:0] BCD_ADJ_HI    = 10'h060;

	typedef struct packed {
		logic [3:0] op;
		logic [7:0] acc_in;
		logic [7:0] index_in;
		logic [7:0] operand;
		logic [7:0] status_in;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] value_out;
		logic [2:0] destination;
		logic [7:0] status_out;
	} alu_rsp_t;

	// decimal unit results
	typedef struct packed {
		logic [7:0] add_value;
		logic       add_n;
		logic       add_v;
		logic       add_c;
		logic [7:0] sub_value;
	} bcd_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/cpu8alu_bcd.sv =====
// Decimal-mode add and subtract adjust for the 8-bit ALU core.
// Depends on cpu8alu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpu8alu_bcd
	import cpu8alu_pkg::*;
(
	input  wire logic [7:0] a,
	input  wire logic [7:0] b,
	input  wire logic       carry_in,
	output bcd_res_t        res
);

	logic [4:0] add_lo;
	logic [4:0] add_lo_adj;
	logic [8:0] add_hi;
	logic [9:0] add_hi_fix;
	logic [5:0] sub_lo;
	logic [5:0] sub_lo_adj;
	logic [9:0] sub_hi;
	logic [9:0] sub_hi_fix;

	// add: low digit, then high digit on top of adjusted low
	always_comb begin
		add_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, carry_in};
		if (add_lo > BCD_DIGIT_MAX) begin
			add_lo_adj = {1'b1, add_lo[3:0] + BCD_ADJ_LO};
		end else begin
			add_lo_adj = add_lo;
		end
		add_hi = {1'b0, a[7:4], 4'b0} + {1'b0, b[7:4], 4'b0} + {4'b0, add_lo_adj};
		if (add_hi >= BCD_HI_LIMIT) begin
			add_hi_fix = {1'b0, add_hi} + BCD_ADJ_HI;
		end else begin
			add_hi_fix = {1'b0, add_hi};
		end
	end

	// subtract: signed digit differences, borrow adjusts
	always_comb begin
		sub_lo = {2'b0, a[3:0]} - {2'b0, b[3:0]} + {5'b0, carry_in} - 6'd1;
		if (sub_lo[5]) begin
			sub_lo_adj = {2'b11, sub_lo[3:0] + BCD_LO_WRAP};
		end else begin
			sub_lo_adj = sub_lo;
		end
		sub_hi = {2'b0, a[7:4], 4'b0} - {2'b0, b[7:4], 4'b0} + {{4{sub_lo_adj[5]}}, sub_lo_adj};
		if (sub_hi[9]) begin
			sub_hi_fix = sub_hi - BCD_ADJ_HI;
		end else begin
			sub_hi_fix = sub_hi;
		end
	end

	assign res.add_value = add_hi_fix[7:0];
	assign res.add_n     = add_hi[7];
	assign res.add_v     = ~(a[7] ^ b[7]) & (a[7] ^ add_hi[7]);
	assign res.add_c     = |add_hi_fix[9:8];
	assign res.sub_value = sub_hi_fix[7:0];

endmodule

`default_nettype wire

// ===== rtl/core/cpu8alu_exec.sv =====
// Combinational operation decode and flag update for the 8-bit ALU core.
// Depends on cpu8alu_pkg and cpu8alu_bcd.
`timescale 1ns / 1ps
`default_nettype none

module cpu8alu_exec
	import cpu8alu_pkg::*;
(
	input  wire alu_req_t req,
	output alu_rsp_t      rsp
);

	logic       carry;
	logic       dec_mode;
	logic [7:0] b_eff;
	logic [8:0] sum;
	logic       bin_v;
	logic [7:0] inc_m;
	logic [7:0] dec_m;
	logic [7:0] inc_ix;
	logic [7:0] dec_ix;
	bcd_res_t   bcd;

	assign carry    = req.status_in[FLAG_C];
	assign dec_mode = req.status_in[FLAG_D];
	assign b_eff    = (req.op == OP_SBC) ? ~req.operand : req.operand;
	assign sum      = {1'b0, req.acc_in} + {1'b0, b_eff} + {8'b0, carry};
	assign bin_v    = ~(req.acc_in[7] ^ b_eff[7]) & (req.acc_in[7] ^ sum[7]);
	assign inc_m    = req.operand + 8'd1;
	assign dec_m    = req.operand - 8'd1;
	assign inc_ix   = req.index_in + 8'd1;
	assign dec_ix   = req.index_in - 8'd1;

	cpu8alu_bcd u_bcd (
		.a        (req.acc_in),
		.b        (req.operand),
		.carry_in (carry),
		.res      (bcd)
	);

	always_comb begin
		logic [7:0] st;
		logic [7:0] val;
		logic [2:0] dest;
		logic       nz_en;
		st    = req.status_in;
		val   = 8'h00;
		dest  = DEST_NONE;
		nz_en = 1'b0;
		unique case (req.op)
			OP_ADC: begin
				dest       = DEST_ACC;
				st[FLAG_Z] = (sum[7:0] == 8'h00);
				if (dec_mode) begin
					val        = bcd.add_value;
					st[FLAG_N] = bcd.add_n;
					st[FLAG_V] = bcd.add_v;
					st[FLAG_C] = bcd.add_c;
				end else begin
					val        = sum[7:0];
					st[FLAG_N] = sum[7];
					st[FLAG_V] = bin_v;
					st[FLAG_C] = sum[8];
				end
			end
			OP_SBC: begin
				// flags always from the binary difference
				dest       = DEST_ACC;
				val        = dec_mode ? bcd.sub_value : sum[7:0];
				st[FLAG_N] = sum[7];
				st[FLAG_Z] = (sum[7:0] == 8'h00);
				st[FLAG_V] = bin_v;
				st[FLAG_C] = sum[8];
			end
			OP_AND: begin
				val = req.acc_in & req.operand; dest = DEST_ACC; nz_en = 1'b1;
			end
			OP_ORA: begin
				val = req.acc_in | req.operand; dest = DEST_ACC; nz_en = 1'b1;
			end
			OP_EOR: begin
				val = req.acc_in ^ req.operand; dest = DEST_ACC; nz_en = 1'b1;
			end
			OP_BIT: begin
				st[FLAG_N] = req.operand[7];
				st[FLAG_V] = req.operand[6];
				st[FLAG_Z] = ((req.acc_in & req.operand) == 8'h00);
			end
			OP_INC: begin
				val = inc_m; dest = DEST_MEM; nz_en = 1'b1;
			end
			OP_DEC: begin
				val = dec_m; dest = DEST_MEM; nz_en = 1'b1;
			end
			OP_INX: begin
				val = inc_ix; dest = DEST_X; nz_en = 1'b1;
			end
			OP_INY: begin
				val = inc_ix; dest = DEST_Y; nz_en = 1'b1;
			end
			OP_DEX: begin
				val = dec_ix; dest = DEST_X; nz_en = 1'b1;
			end
			OP_DEY: begin
				val = dec_ix; dest = DEST_Y; nz_en = 1'b1;
			end
			default: begin
				// unused codes: no-op
				val  = 8'h00;
				dest = DEST_NONE;
			end
		endcase
		if (nz_en) begin
			st[FLAG_N] = val[7];
			st[FLAG_Z] = (val == 8'h00);
		end
		rsp.value_out   = val;
		rsp.destination = dest;
		rsp.status_out  = st;
	end

endmodule

`default_nettype wire

// ===== rtl/core/cpu8_alu_with_bcd.sv =====
// Top level of the 8-bit ALU core with decimal-mode add and subtract.
// Depends on cpu8alu_pkg, cpu8alu_exec, cpu8alu_bcd and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "cpu8_alu_with_bcd_assert.svh"

// Usage
// -----
// Command channel: drive a word on req and raise start; the word is taken at
// any rising edge where start is high and busy is low. busy is never raised:
// the core takes a new word every cycle.
// Result channel: rsp carries value, destination and updated status; done
// marks it for exactly one cycle and the receiver must take it then, since
// it cannot stall the core.
// Path: a taken word is held in the input register, passes the combinational
// ALU into the result register, and then shows on rsp with done high.
// Throughput: one word per cycle, sustained. The figure is set by the single
// combinational pass (binary add, decimal adjust, flag merge) between the
// input register and the result register.
// Reset: arst_n low clears both valid flags at once; no result is shown
// until a new word is taken. Payload registers are not reset.
// Status bits not touched by an op pass straight through, D included.
module cpu8_alu_with_bcd
	import cpu8alu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire alu_req_t req,
	output logic          done,
	output alu_rsp_t      rsp
);

	logic     accept;
	logic     valid_s1;
	alu_req_t req_s1;
	alu_rsp_t rsp_comb;
	logic     valid_s2;
	alu_rsp_t rsp_s2;

	// never stalls: the ALU pass is combinational and the receiver cannot push back
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// single combinational pass
	cpu8alu_exec u_exec (
		.req (req_s1),
		.rsp (rsp_comb)
	);

	// stage 2: result register, drives the strobe and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign done = valid_s2;
	assign rsp  = rsp_s2;

	// checks
	`CPU8ALU_ASSERT_NEXT(a_accept_to_s1, clk, arst_n, accept, valid_s1,
		"accepted word lost at stage 1")
	`CPU8ALU_ASSERT_NEXT(a_s1_to_done, clk, arst_n, valid_s1 == 1'b1, done,
		"stage 1 word not strobed out")
	`CPU8ALU_ASSERT_NOW(a_dest_range, clk, arst_n, done,
		rsp.destination == DEST_ACC || rsp.destination == DEST_X ||
		rsp.destination == DEST_Y || rsp.destination == DEST_MEM ||
		rsp.destination == DEST_NONE,
		"destination code out of range")
	`CPU8ALU_ASSERT_NOW(a_none_zero, clk, arst_n, done && rsp.destination == DEST_NONE,
		rsp.value_out == 8'h00, "value not zero for no destination")
	`CPU8ALU_ASSERT_NOW(a_status_pass, clk, arst_n, done,
		rsp.status_out[5:2] == $past(req.status_in[5:2], 2),
		"untouched status bits changed")

endmodule

`default_nettype wire

// ===== bench/cpu8_alu_checker.sv =====
// Result checker for the 8-bit ALU: predicts each word taken on the command
// channel and compares it with the word shown on the result channel.
// Depends on cpu8alu_pkg.
`timescale 1ns / 1ps

module cpu8_alu_checker
	import cpu8alu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  alu_req_t req,
	input  logic     done,
	input  alu_rsp_t rsp,
	output int       errors,
	output int       outstanding
);

	alu_rsp_t pending_results[$];

	initial begin
		errors = 0;
		outstanding = 0;
	end

	// value, destination and new status for one command word
	function automatic alu_rsp_t alu_result(alu_req_t w);
		logic [8:0] sum;
		logic [7:0] b;
		logic       cin;
		logic       nz_from_value;
		logic [4:0] lo_sum;
		logic [9:0] hi_sum;
		int         lo_diff;
		int         hi_diff;
		alu_rsp_t   r;
		r.value_out = '0;
		r.destination = DEST_NONE;
		r.status_out = w.status_in;
		cin = w.status_in[FLAG_C];
		nz_from_value = 1'b0;
		case (w.op)
		OP_ADC, OP_SBC: begin
			b = (w.op == OP_SBC) ? ~w.operand : w.operand;
			sum = {1'b0, w.acc_in} + {1'b0, b} + {8'd0, cin};
			r.destination = DEST_ACC;
			r.value_out = sum[7:0];
			r.status_out[FLAG_N] = sum[7];
			r.status_out[FLAG_Z] = (sum[7:0] == 8'd0);
			r.status_out[FLAG_V] = ~(w.acc_in[7] ^ b[7]) & (w.acc_in[7] ^ sum[7]);
			r.status_out[FLAG_C] = sum[8];
			if (w.status_in[FLAG_D] && w.op == OP_ADC) begin
				// low digit fixed first; N and V seen before the high fix, Z stays binary
				lo_sum = {1'b0, w.acc_in[3:0]} + {1'b0, w.operand[3:0]} + {4'd0, cin};
				if (lo_sum > 5'd9)
					lo_sum = ((lo_sum + 5'd6) & 5'h0F) + 5'h10;
				hi_sum = {2'b0, w.acc_in[7:4], 4'b0} + {2'b0, w.operand[7:4], 4'b0}
					+ {5'd0, lo_sum};
				r.status_out[FLAG_N] = hi_sum[7];
				r.status_out[FLAG_V] = ~(w.acc_in[7] ^ w.operand[7]) & (w.acc_in[7] ^ hi_sum[7]);
				if (hi_sum >= 10'h0A0)
					hi_sum = hi_sum + 10'h060;
				r.status_out[FLAG_C] = (hi_sum > 10'h0FF);
				r.value_out = hi_sum[7:0];
			end else if (w.status_in[FLAG_D]) begin
				// decimal subtract: flags stay binary, value adjusted on borrows
				lo_diff = int'(w.acc_in[3:0]) - int'(w.operand[3:0]) + int'(cin) - 1;
				if (lo_diff < 0)
					lo_diff = ((lo_diff + 26) & 15) - 16;
				hi_diff = int'({w.acc_in[7:4], 4'b0}) - int'({w.operand[7:4], 4'b0}) + lo_diff;
				if (hi_diff < 0)
					hi_diff = hi_diff - 96;
				r.value_out = 8'(hi_diff + 512);
			end
		end
		OP_AND: begin
			r.value_out = w.acc_in & w.operand;
			r.destination = DEST_ACC;
			nz_from_value = 1'b1;
		end
		OP_ORA: begin
			r.value_out = w.acc_in | w.operand;
			r.destination = DEST_ACC;
			nz_from_value = 1'b1;
		end
		OP_EOR: begin
			r.value_out = w.acc_in ^ w.operand;
			r.destination = DEST_ACC;
			nz_from_value = 1'b1;
		end
		OP_BIT: begin
			r.status_out[FLAG_N] = w.operand[7];
			r.status_out[FLAG_V] = w.operand[6];
			r.status_out[FLAG_Z] = ((w.acc_in & w.operand) == 8'd0);
		end
		OP_INC: begin
			r.value_out = w.operand + 8'd1;
			r.destination = DEST_MEM;
			nz_from_value = 1'b1;
		end
		OP_DEC: begin
			r.value_out = w.operand - 8'd1;
			r.destination = DEST_MEM;
			nz_from_value = 1'b1;
		end
		OP_INX, OP_INY: begin
			r.value_out = w.index_in + 8'd1;
			r.destination = (w.op == OP_INX) ? DEST_X : DEST_Y;
			nz_from_value = 1'b1;
		end
		OP_DEX, OP_DEY: begin
			r.value_out = w.index_in - 8'd1;
			r.destination = (w.op == OP_DEX) ? DEST_X : DEST_Y;
			nz_from_value = 1'b1;
		end
		default: ;
		endcase
		if (nz_from_value) begin
			r.status_out[FLAG_N] = r.value_out[7];
			r.status_out[FLAG_Z] = (r.value_out == 8'd0);
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: MISMATCH %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		alu_rsp_t want;
		if (arst_n) begin
			if ($isunknown(done)) begin
				report_mismatch("done strobe unknown");
			end else if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %p", rsp));
				end else begin
					want = pending_results.pop_front();
					if (rsp.value_out !== want.value_out)
						report_mismatch($sformatf("value_out %h, want %h",
							rsp.value_out, want.value_out));
					if (rsp.destination !== want.destination)
						report_mismatch($sformatf("destination %0d, want %0d",
							rsp.destination, want.destination));
					if (rsp.status_out !== want.status_out)
						report_mismatch($sformatf("status_out %b, want %b",
							rsp.status_out, want.status_out));
				end
			end
			if (start && !busy)
				pending_results.push_back(alu_result(req));
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// Top of the ALU testbench: clock, reset, command stimulus and verdict.
// Depends on cpu8alu_pkg, cpu8_alu_with_bcd and cpu8_alu_checker.
`timescale 1ns / 1ps

module tb;
	import cpu8alu_pkg::*;

	// op codes 12..15 have no name in the package; the core treats them as no-ops
	localparam logic [3:0] OP_UNUSED_LO = 4'd12;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;

	// single-flag status bytes
	localparam logic [7:0] ST_C = 8'(1 << FLAG_C);
	localparam logic [7:0] ST_D = 8'(1 << FLAG_D);

	localparam int RANDOM_PER_PHASE = 250;
	// cycles with no word taken on either channel before giving up
	localparam int WATCHDOG_LIMIT = 500;
	// a taken word passes the input and result registers before its result is taken; allow a margin
	localparam int DRAIN_CYCLES = 8;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	alu_req_t req = '0;
	logic     busy;
	logic     done;
	alu_rsp_t rsp;
	int       errors;
	int       outstanding;
	int       quiet_cycles = 0;

	// sender idle percentage per phase: light, heavy, none
	int       idle_pct[3] = '{11, 62, 0};
	alu_req_t directed[$];

	always #5 clk = ~clk;

	cpu8_alu_with_bcd u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	cpu8_alu_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	function automatic alu_req_t make_word(logic [3:0] op, logic [7:0] a, logic [7:0] ix,
		logic [7:0] m, logic [7:0] st);
		alu_req_t w;
		w.op = op;
		w.acc_in = a;
		w.index_in = ix;
		w.operand = m;
		w.status_in = st;
		return w;
	endfunction

	// Mostly the twelve real ops, some unused codes. Half the add/subtract
	// words are forced into decimal mode, and most of those carry valid BCD
	// digits; the rest exercise the adjust on invalid digits.
	function automatic alu_req_t random_word();
		alu_req_t w;
		if ($urandom_range(0, 9) == 0)
			w.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		else
			w.op = 4'($urandom_range(OP_ADC, OP_DEY));
		w.acc_in = 8'($urandom);
		w.index_in = 8'($urandom);
		w.operand = 8'($urandom);
		w.status_in = 8'($urandom);
		if ((w.op == OP_ADC || w.op == OP_SBC) && $urandom_range(0, 1) == 1) begin
			w.status_in[FLAG_D] = 1'b1;
			if ($urandom_range(0, 3) != 0) begin
				w.acc_in = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
				w.operand = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
			end
		end
		return w;
	endfunction

	// Called at a falling edge. Idles at random, then holds start and the
	// word until a rising edge with busy low takes it; returns at the next
	// falling edge so that each step sees one assignment per signal.
	task automatic send_word(alu_req_t w, int idle);
		while ($urandom_range(0, 99) < idle) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Watchdog: the core may never go quiet on both channels for long once
	// out of reset. A stuck core or a lost result lands here.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		// binary add: signed overflow, then carry in giving zero and carry out
		directed.push_back(make_word(OP_ADC, 8'h7F, 8'h00, 8'h01, 8'h00));
		directed.push_back(make_word(OP_ADC, 8'hFF, 8'hFF, 8'h00, ST_C));
		// decimal add: 99+1 wraps to 00 (Z from the binary sum stays clear),
		// an ordinary carry chain, and invalid digits through the adjust
		directed.push_back(make_word(OP_ADC, 8'h99, 8'h00, 8'h01, ST_D));
		directed.push_back(make_word(OP_ADC, 8'h58, 8'h00, 8'h46, ST_D | ST_C));
		directed.push_back(make_word(OP_ADC, 8'hFF, 8'h00, 8'hFF, ST_D | ST_C));
		// binary subtract: borrow out, and signed overflow
		directed.push_back(make_word(OP_SBC, 8'h00, 8'h00, 8'h01, ST_C));
		directed.push_back(make_word(OP_SBC, 8'h80, 8'h00, 8'h01, ST_C));
		// decimal subtract: 00-01 borrows to 99, plain case, invalid digits
		directed.push_back(make_word(OP_SBC, 8'h00, 8'h00, 8'h01, ST_D | ST_C));
		directed.push_back(make_word(OP_SBC, 8'h46, 8'h00, 8'h12, ST_D | ST_C));
		directed.push_back(make_word(OP_SBC, 8'hAF, 8'h00, 8'hFF, ST_D));
		// logic ops: zero result with all flags set, sign set, self-cancel
		directed.push_back(make_word(OP_AND, 8'hF0, 8'hFF, 8'h0F, 8'hFF));
		directed.push_back(make_word(OP_ORA, 8'h80, 8'h00, 8'h01, 8'h00));
		directed.push_back(make_word(OP_EOR, 8'hFF, 8'h00, 8'hFF, 8'h00));
		// BIT: N and V straight from the operand, Z from the mask
		directed.push_back(make_word(OP_BIT, 8'h00, 8'h00, 8'hC0, 8'h00));
		directed.push_back(make_word(OP_BIT, 8'hFF, 8'h00, 8'h3F, 8'hFF));
		// increments and decrements across the wrap points
		directed.push_back(make_word(OP_INC, 8'h00, 8'h00, 8'hFF, 8'h00));
		directed.push_back(make_word(OP_DEC, 8'hFF, 8'h00, 8'h00, 8'hFF));
		directed.push_back(make_word(OP_INX, 8'h00, 8'hFF, 8'h00, 8'h00));
		directed.push_back(make_word(OP_INY, 8'h00, 8'h7F, 8'h00, 8'hFF));
		directed.push_back(make_word(OP_DEX, 8'h00, 8'h00, 8'h00, 8'h00));
		directed.push_back(make_word(OP_DEY, 8'h00, 8'h01, 8'h00, 8'hFF));
		// unused codes leave status alone and write nowhere
		for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
			directed.push_back(make_word(4'(op), 8'hFF, 8'hFF, 8'hFF,
				(op[0]) ? 8'hFF : 8'h00));

		// reset held low, then released away from the rising edge
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_word(directed[i], idle_pct[0]);

		for (int phase = 0; phase < 3; phase++)
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_word(random_word(), idle_pct[phase]);

		start <= 1'b0;
		// a lost result keeps this waiting and the watchdog ends the run
		while (outstanding != 0)
			@(negedge clk);
		// room for any stray result to show
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
